// ----- src/arc_pkg.sv -----
`timescale 1ns / 1ps
// arc_pkg: shared types and codes of the arp address cache
package arc_pkg;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_ADD    = 1'b1;

    localparam logic [2:0] ST_MISS     = 3'd0;
    localparam logic [2:0] ST_HIT      = 3'd1;
    localparam logic [2:0] ST_UPDATED  = 3'd2;
    localparam logic [2:0] ST_INSERTED = 3'd3;
    localparam logic [2:0] ST_DROPPED  = 3'd4;

    typedef struct packed {
        logic        req_type;
        logic [31:0] ip_addr;
        logic [47:0] mac_addr;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] mac_out;
    } rsp_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
    } stat_t;

endpackage

// ----- src/arc_ctrl.sv -----
`timescale 1ns / 1ps
// arc_ctrl: sequencing state machine of the arp address cache
module arc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output arc_pkg::cmd_t cmd,
    input  arc_pkg::stat_t stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    always_comb
    begin
        cmd.start  = (state_reg == S_IDLE) && req_valid;
        cmd.scan   = (state_reg == S_SCAN);
        cmd.finish = (state_reg == S_FINISH) && (!rsp_valid_reg || rsp_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (cmd.finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

// ----- src/arc_datapath.sv -----
`timescale 1ns / 1ps
// arc_datapath: entry storage, scan and result logic of the arp address cache
module arc_datapath #(
    parameter int ENTRIES = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  arc_pkg::req_t  req,
    output arc_pkg::rsp_t  rsp,
    input  arc_pkg::cmd_t  cmd,
    output arc_pkg::stat_t stat
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic [31:0] addr_mem [ENTRIES];
    logic [47:0] mac_mem  [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;

    arc_pkg::req_t req_reg;
    arc_pkg::rsp_t rsp_reg;
    arc_pkg::rsp_t rsp_next;

    logic [CW-1:0] scan_cnt_reg;
    logic [CW-1:0] scan_cnt_next;
    logic          stage_valid_reg;
    logic          stage_valid_next;
    logic [IW-1:0] rd_idx_reg;
    logic [31:0]   rd_addr_reg;
    logic [47:0]   rd_mac_reg;

    logic          match_found_reg;
    logic          match_found_next;
    logic [IW-1:0] match_idx_reg;
    logic [IW-1:0] match_idx_next;
    logic [47:0]   match_mac_reg;
    logic [47:0]   match_mac_next;
    logic          free_found_reg;
    logic          free_found_next;
    logic [IW-1:0] free_idx_reg;
    logic [IW-1:0] free_idx_next;

    logic          scan_issue;
    logic          stage_hit;
    logic          stage_free;
    logic          wr_mac_en;
    logic          wr_addr_en;
    logic [IW-1:0] wr_idx;

    assign scan_issue = cmd.scan && (scan_cnt_reg != CW'(ENTRIES));
    assign stage_hit  = cmd.scan && stage_valid_reg && valid_reg[rd_idx_reg]
                        && (rd_addr_reg == req_reg.ip_addr);
    assign stage_free = cmd.scan && stage_valid_reg && !valid_reg[rd_idx_reg];

    always_comb
    begin
        scan_cnt_next    = scan_cnt_reg;
        stage_valid_next = stage_valid_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        match_mac_next   = match_mac_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        if (cmd.start)
        begin
            scan_cnt_next    = '0;
            stage_valid_next = 1'b0;
            match_found_next = 1'b0;
            free_found_next  = 1'b0;
        end
        else if (cmd.scan)
        begin
            stage_valid_next = scan_issue;
            if (scan_issue)
            begin
                scan_cnt_next = scan_cnt_reg + CW'(1);
            end
            if (stage_hit && !match_found_reg)
            begin
                match_found_next = 1'b1;
                match_idx_next   = rd_idx_reg;
                match_mac_next   = rd_mac_reg;
            end
            if (stage_free && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = rd_idx_reg;
            end
        end
    end

    always_comb
    begin
        rsp_next   = rsp_reg;
        valid_next = valid_reg;
        wr_mac_en  = 1'b0;
        wr_addr_en = 1'b0;
        wr_idx     = match_idx_reg;
        if (cmd.finish)
        begin
            rsp_next.mac_out = '0;
            priority if (req_reg.req_type == arc_pkg::REQ_LOOKUP)
            begin
                if (match_found_reg)
                begin
                    rsp_next.status  = arc_pkg::ST_HIT;
                    rsp_next.mac_out = match_mac_reg;
                end
                else
                begin
                    rsp_next.status = arc_pkg::ST_MISS;
                end
            end
            else if (match_found_reg)
            begin
                rsp_next.status = arc_pkg::ST_UPDATED;
                wr_mac_en       = 1'b1;
            end
            else if (free_found_reg)
            begin
                rsp_next.status       = arc_pkg::ST_INSERTED;
                wr_mac_en             = 1'b1;
                wr_addr_en            = 1'b1;
                wr_idx                = free_idx_reg;
                valid_next[free_idx_reg] = 1'b1;
            end
            else
            begin
                rsp_next.status = arc_pkg::ST_DROPPED;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr_addr_en)
        begin
            addr_mem[wr_idx] <= req_reg.ip_addr;
        end
        if (wr_mac_en)
        begin
            mac_mem[wr_idx] <= req_reg.mac_addr;
        end
        if (scan_issue)
        begin
            rd_addr_reg <= addr_mem[scan_cnt_reg[IW-1:0]];
            rd_mac_reg  <= mac_mem[scan_cnt_reg[IW-1:0]];
            rd_idx_reg  <= scan_cnt_reg[IW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_reg <= req;
        end
        rsp_reg       <= rsp_next;
        scan_cnt_reg  <= scan_cnt_next;
        match_idx_reg <= match_idx_next;
        match_mac_reg <= match_mac_next;
        free_idx_reg  <= free_idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            stage_valid_reg <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else
        begin
            valid_reg       <= valid_next;
            stage_valid_reg <= stage_valid_next;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
        end
    end

    assign stat.scan_done = (scan_cnt_reg == CW'(ENTRIES)) && !stage_valid_reg;
    assign rsp            = rsp_reg;

endmodule

// ----- src/arp_address_cache.sv -----
`timescale 1ns / 1ps
// arp_address_cache: top level of the ip to mac address cache
//
//   channel   dir   handshake              item
//   req       in    req_valid / req_ready  arc_pkg::req_t
//   rsp       out   rsp_valid / rsp_ready  arc_pkg::rsp_t
//
// one item at a time; the scan reads one entry per cycle from the entry memory
// reset clears all valid marks at once; entry contents are not cleared
// a stalled result holds in the output register; req_ready returns once it is loaded
module arp_address_cache #(
    parameter int ENTRIES = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  arc_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output arc_pkg::rsp_t rsp
);

    arc_pkg::cmd_t  cmd;
    arc_pkg::stat_t stat;

    arc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    arc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

// ----- src/arc_checker.sv -----
`timescale 1ns / 1ps
// arc_checker: port level checks of the arp address cache and its bind
module arc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input arc_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input arc_pkg::rsp_t rsp
);

    // a waiting request item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("waiting request changed");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

    // one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("second item taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == arc_pkg::ST_MISS) || (rsp.status == arc_pkg::ST_HIT)
            || (rsp.status == arc_pkg::ST_UPDATED) || (rsp.status == arc_pkg::ST_INSERTED)
            || (rsp.status == arc_pkg::ST_DROPPED))
    else $error("status code out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != arc_pkg::ST_HIT) |-> (rsp.mac_out == '0))
    else $error("mac nonzero without a hit");

endmodule

bind arp_address_cache arc_checker u_arc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ----- dv/arp_address_cache_tb.sv -----
`timescale 1ns / 1ps
// arp_address_cache_tb: self-checking testbench of the ip to mac address cache
module arp_address_cache_tb;

    localparam int ENTRIES      = 8;
    localparam int RANDOM_ITEMS = 1800;
    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES  = 40;

    typedef struct {
        arc_pkg::req_t payload;
        bit            drain;
    } pending_item_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_ready;
    arc_pkg::req_t  req       = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    arc_pkg::rsp_t  rsp;

    pending_item_t pending[$];
    arc_pkg::rsp_t cache_expected[$];

    logic [31:0] tbl_ip   [ENTRIES];
    logic [47:0] tbl_mac  [ENTRIES];
    logic        tbl_used [ENTRIES];

    int unsigned n_accepted = 0;
    int unsigned n_checked  = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    int drv_gap   = 0;
    bit drv_burst = 1'b0;
    int rsp_wait  = 0;
    int rsp_hold  = 0;
    bit rsp_burst = 1'b0;

    arp_address_cache #(
        .ENTRIES(ENTRIES)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic predict_cache(input arc_pkg::req_t r);
        int            hit_slot  = -1;
        int            free_slot = -1;
        arc_pkg::rsp_t e;
        for (int k = 0; k < ENTRIES; k++)
        begin
            if (hit_slot < 0 && tbl_used[k] && tbl_ip[k] == r.ip_addr)
                hit_slot = k;
            if (free_slot < 0 && !tbl_used[k])
                free_slot = k;
        end
        e.mac_out = '0;
        if (r.req_type == arc_pkg::REQ_LOOKUP)
        begin
            if (hit_slot >= 0)
            begin
                e.status  = arc_pkg::ST_HIT;
                e.mac_out = tbl_mac[hit_slot];
            end
            else
                e.status = arc_pkg::ST_MISS;
        end
        else if (hit_slot >= 0)
        begin
            tbl_mac[hit_slot] = r.mac_addr;
            e.status = arc_pkg::ST_UPDATED;
        end
        else if (free_slot >= 0)
        begin
            tbl_ip[free_slot]   = r.ip_addr;
            tbl_mac[free_slot]  = r.mac_addr;
            tbl_used[free_slot] = 1'b1;
            e.status = arc_pkg::ST_INSERTED;
        end
        else
            e.status = arc_pkg::ST_DROPPED;
        cache_expected.push_back(e);
    endtask

    task automatic check_response(input arc_pkg::rsp_t got);
        arc_pkg::rsp_t want;
        if (cache_expected.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result status %0d mac %012h",
                                      got.status, got.mac_out));
            return;
        end
        want = cache_expected.pop_front();
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.mac_out !== want.mac_out)
            report_mismatch($sformatf("mac_out %012h, want %012h",
                                      got.mac_out, want.mac_out));
    endtask

    task automatic queue_item(input logic kind, input logic [31:0] ip,
                              input logic [47:0] mac, input bit drain);
        pending_item_t p;
        p.payload.req_type = kind;
        p.payload.ip_addr  = ip;
        p.payload.mac_addr = mac;
        p.drain            = drain;
        pending.push_back(p);
    endtask

    // driver
    always @(posedge clk)
    begin : driver
        logic          fire;
        logic          next_valid;
        arc_pkg::req_t next_req;
        int unsigned   acc_now;
        pending_item_t item;
        if (rst_n)
        begin
            fire       = req_valid && req_ready;
            next_valid = req_valid && !fire;
            next_req   = req;
            acc_now    = n_accepted;
            if (fire)
            begin
                predict_cache(req);
                acc_now = n_accepted + 1;
                n_accepted <= acc_now;
                drv_gap = drv_burst ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 63) == 0)
                    drv_burst = !drv_burst;
            end
            if (!next_valid)
            begin
                if (drv_gap > 0)
                    drv_gap--;
                else if (pending.size() > 0 && !(pending[0].drain && acc_now != n_checked))
                begin
                    item       = pending.pop_front();
                    next_valid = 1'b1;
                    next_req   = item.payload;
                end
            end
            req_valid <= next_valid;
            req       <= next_req;
        end
    end

    // monitor
    always @(posedge clk)
    begin : monitor
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                check_response(rsp);
                n_checked <= n_checked + 1;
                rsp_wait = rsp_burst ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 63) == 0)
                    rsp_burst = !rsp_burst;
                // one long stall so the block backs up its input
                if (n_checked == 700)
                    rsp_hold = 400;
            end
            else if (rsp_hold > 0)
                rsp_hold--;
            else if (rsp_wait > 0)
                rsp_wait--;
            rsp_ready <= (rsp_wait == 0 && rsp_hold == 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] table_ip [ENTRIES];
        logic [31:0] ip;
        logic [63:0] r64;
        int          pick;

        for (int k = 0; k < ENTRIES; k++)
        begin
            tbl_ip[k]   = '0;
            tbl_mac[k]  = '0;
            tbl_used[k] = 1'b0;
        end

        table_ip = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hC0A8_0001, 32'hAAAA_AAAA,
                     32'h5555_5555, 32'h0A00_0001, 32'h7F00_0001, 32'h8000_0000};

        // empty table, then fill, update and overflow
        queue_item(arc_pkg::REQ_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b0);
        queue_item(arc_pkg::REQ_ADD,    32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b0);
        queue_item(arc_pkg::REQ_LOOKUP, 32'h0000_0000, 48'h0,              1'b0);
        queue_item(arc_pkg::REQ_ADD,    32'h0000_0000, 48'h0,              1'b0);
        queue_item(arc_pkg::REQ_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b0);
        queue_item(arc_pkg::REQ_ADD,    32'hFFFF_FFFF, 48'h0,              1'b0);
        queue_item(arc_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 48'h0,              1'b0);
        queue_item(arc_pkg::REQ_LOOKUP, 32'h0000_0001, 48'h0,              1'b0);
        queue_item(arc_pkg::REQ_LOOKUP, 32'hFFFF_FFFE, 48'h0,              1'b0);
        queue_item(arc_pkg::REQ_ADD,    table_ip[2],   48'hAAAA_AAAA_AAAA, 1'b0);
        queue_item(arc_pkg::REQ_ADD,    table_ip[3],   48'h5555_5555_5555, 1'b0);
        queue_item(arc_pkg::REQ_ADD,    table_ip[4],   48'h0123_4567_89AB, 1'b0);
        queue_item(arc_pkg::REQ_ADD,    table_ip[5],   48'hFEDC_BA98_7654, 1'b0);
        queue_item(arc_pkg::REQ_ADD,    table_ip[6],   48'h8000_0000_0001, 1'b0);
        queue_item(arc_pkg::REQ_ADD,    table_ip[7],   48'h7FFF_FFFF_FFFE, 1'b0);
        queue_item(arc_pkg::REQ_ADD,    32'h1234_5678, 48'hFFFF_FFFF_FFFF, 1'b0);
        queue_item(arc_pkg::REQ_LOOKUP, 32'h1234_5678, 48'h0,              1'b0);
        queue_item(arc_pkg::REQ_ADD,    table_ip[3],   48'hFFFF_FFFF_FFFF, 1'b0);
        queue_item(arc_pkg::REQ_LOOKUP, table_ip[3],   48'h0,              1'b0);
        queue_item(arc_pkg::REQ_LOOKUP, table_ip[7],   48'h0,              1'b0);
        queue_item(arc_pkg::REQ_LOOKUP, table_ip[2],   48'h0,              1'b0);

        // random: mostly stored addresses, some near misses and fresh ones
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                ip = table_ip[$urandom_range(0, ENTRIES - 1)];
            else if (pick < 7)
                ip = table_ip[$urandom_range(0, ENTRIES - 1)] ^ (32'h1 << $urandom_range(0, 31));
            else
                ip = $urandom;
            r64 = {$urandom, $urandom};
            queue_item(logic'($urandom_range(0, 1)), ip, r64[47:0], i == 900);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || req_valid || n_checked < n_accepted)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (cache_expected.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", cache_expected.size()));

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
src/arc_pkg.sv
src/arc_ctrl.sv
src/arc_datapath.sv
src/arp_address_cache.sv
src/arc_checker.sv
dv/arp_address_cache_tb.sv
